// ----- hdl/bpts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpts_pkg;

	// Program table depth and index width
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		PH_STOP   = 3'd0,
		PH_HV_POS = 3'd1,
		PH_HV_NEG = 3'd2,
		PH_LV_POS = 3'd3,
		PH_LV_NEG = 3'd4
	} phase_t;

	// Entry field selects
	localparam logic [3:0] FLD_POS_EL     = 4'd0;
	localparam logic [3:0] FLD_NEG_EL     = 4'd1;
	localparam logic [3:0] FLD_HV_POS_CNT = 4'd2;
	localparam logic [3:0] FLD_HV_NEG_CNT = 4'd3;
	localparam logic [3:0] FLD_LV_POS_CNT = 4'd4;
	localparam logic [3:0] FLD_LV_NEG_CNT = 4'd5;
	localparam logic [3:0] FLD_SEQ_DLY    = 4'd6;
	localparam logic [3:0] FLD_HV_DLY     = 4'd7;
	localparam logic [3:0] FLD_LV_DLY     = 4'd8;
	localparam logic [3:0] FLD_PULSE_DLY  = 4'd9;
	localparam logic [3:0] FLD_HV_ON      = 4'd10;
	localparam logic [3:0] FLD_HV_OFF     = 4'd11;
	localparam logic [3:0] FLD_LV_ON      = 4'd12;
	localparam logic [3:0] FLD_LV_OFF     = 4'd13;
	localparam logic [3:0] FLD_VALID      = 4'd14;

	// Slots of the packed time row (16 bits each)
	localparam int T_SEQ_DLY   = 0;
	localparam int T_HV_DLY    = 1;
	localparam int T_LV_DLY    = 2;
	localparam int T_PULSE_DLY = 3;
	localparam int T_HV_ON     = 4;
	localparam int T_HV_OFF    = 5;
	localparam int T_LV_ON     = 6;
	localparam int T_LV_OFF    = 7;
	localparam int N_TIMES     = 8;

	// Bit of field_value that carries the valid mark
	localparam int VALID_BIT = 7;

	// Supply switch and pole mode codes
	localparam logic [1:0] SW_OFF     = 2'd0;
	localparam logic [1:0] SW_HV      = 2'd1;
	localparam logic [1:0] SW_LV      = 2'd2;
	localparam logic [1:0] SW_KEEP    = 2'd3;
	localparam logic [1:0] POLE_FLOAT = 2'd0;
	localparam logic [1:0] POLE_LOW   = 2'd1;
	localparam logic [1:0] POLE_PULSE = 2'd2;
	localparam logic [1:0] POLE_KEEP  = 2'd3;

	// Table write / clear request
	typedef struct packed {
		logic        en;
		logic        clr;
		idx_t        idx;
		logic [3:0]  field;
		logic [15:0] value;
	} tbl_wr_t;

	// Entry contents seen by the sequencer
	typedef struct packed {
		logic [31:0]         counts;
		logic [16*N_TIMES-1:0] times;
	} entry_rd_t;

endpackage

`default_nettype wire

// ----- hdl/bpts_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpts_table
	import bpts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tbl_wr_t   wr,
	input  wire idx_t      rd_idx,
	input  wire idx_t      pole_idx,
	input  wire idx_t      vld_idx,
	output entry_rd_t      rd,
	output logic [7:0]     poles,
	output logic           vld
);

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0]            counts_q [TABLE_DEPTH];
	logic [16*N_TIMES-1:0]  times_q  [TABLE_DEPTH];
	logic [7:0]             poles_q  [TABLE_DEPTH];
	logic [3:0]             slot_off;
	logic [2:0]             slot;

	assign slot_off = wr.field - FLD_SEQ_DLY;
	assign slot     = slot_off[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clr) begin
			valid_q <= '0;
		end else if (wr.en && wr.field == FLD_VALID) begin
			valid_q[wr.idx] <= wr.value[VALID_BIT];
		end
	end

	// Entry payload, undefined until written
	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.field)
				FLD_POS_EL:     poles_q[wr.idx][3:0] <= wr.value[3:0];
				FLD_NEG_EL:     poles_q[wr.idx][7:4] <= wr.value[3:0];
				FLD_HV_POS_CNT: counts_q[wr.idx][7:0]   <= wr.value[7:0];
				FLD_HV_NEG_CNT: counts_q[wr.idx][15:8]  <= wr.value[7:0];
				FLD_LV_POS_CNT: counts_q[wr.idx][23:16] <= wr.value[7:0];
				FLD_LV_NEG_CNT: counts_q[wr.idx][31:24] <= wr.value[7:0];
				FLD_SEQ_DLY, FLD_HV_DLY, FLD_LV_DLY, FLD_PULSE_DLY,
				FLD_HV_ON, FLD_HV_OFF, FLD_LV_ON, FLD_LV_OFF: begin
					times_q[wr.idx][{slot, 4'd0} +: 16] <= wr.value;
				end
				default: ;
			endcase
		end
	end

	assign rd.counts = counts_q[rd_idx];
	assign rd.times  = times_q[rd_idx];
	assign vld       = valid_q[vld_idx];

	// Electrode read sees a same-beat write
	always_comb begin
		poles = poles_q[pole_idx];
		if (wr.en && wr.idx == pole_idx) begin
			if (wr.field == FLD_POS_EL) begin
				poles[3:0] = wr.value[3:0];
			end
			if (wr.field == FLD_NEG_EL) begin
				poles[7:4] = wr.value[3:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bipolar_pulse_train_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata bits                                  tuser bits
// s_*      in   entry_index, field_value, pos/neg_pole_done cmd, field_select
// m_*      out  modes, train timing, electrodes, status     -
//
// One beat in, one beat out. A beat is held in the input register, is
// decoded there against the sequencer state and the table row at entry_ptr,
// and lands in the result register; one beat per cycle while m_tready holds.
// The input register refills while a result waits; back-pressure on m_ reaches
// s_tready only when both registers are full.
// arst_n clears phase, run flag, entry pointer and valid marks; table payload
// is not cleared and must be written before it is used.

module bipolar_pulse_train_sequencer_core
	import bpts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [3:0] entry_index, [19:4] field_value, [20] pos_pole_done,
	// [21] neg_pole_done, [23:22] zero
	input  wire logic [23:0] s_tdata,
	// [2:0] cmd, [6:3] field_select
	input  wire logic [6:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] switch_mode, [3:2] pos_mode, [5:4] neg_mode, [21:6] train_delay_ms,
	// [37:22] train_on_ms, [53:38] train_off_ms, [61:54] train_count,
	// [65:62] pos_electrode, [69:66] neg_electrode, [70] stop_report,
	// [73:71] phase, [74] enabled, [79:75] zero
	output logic [79:0]      m_tdata
);

	// input register
	logic        vld_s1;
	logic [2:0]  cmd_s1;
	logic [3:0]  idx_s1;
	logic [3:0]  fsel_s1;
	logic [15:0] fval_s1;
	logic        pdone_s1;
	logic        ndone_s1;
	logic        fire_s1;

	// sequencer state
	phase_t      phase_q;
	logic        run_q;
	idx_t        ptr_q;

	// result register
	logic        out_vld_q;
	logic [74:0] res_q;

	// next state / result
	phase_t      phase_n;
	logic        run_n;
	idx_t        ptr_n;
	logic [1:0]  sw_mode;
	logic [1:0]  p_mode;
	logic [1:0]  n_mode;
	logic [15:0] t_dly;
	logic [15:0] t_on;
	logic [15:0] t_off;
	logic [7:0]  t_cnt;
	logic        rpt;

	// table side
	tbl_wr_t     tbl_wr;
	entry_rd_t   cur;
	logic [7:0]  poles_n;
	logic        nx_vld;
	idx_t        ptr_inc;
	logic        ptr_last;

	// train search
	logic [2:0]  adv_from;
	logic [2:0]  adv_sel;
	logic        adv_found;
	logic        adv_hv;
	logic        adv_pos;
	logic [15:0] adv_dly;
	logic        pole_done;

	assign fire_s1  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser[2:0];
			fsel_s1  <= s_tuser[6:3];
			idx_s1   <= s_tdata[3:0];
			fval_s1  <= s_tdata[19:4];
			pdone_s1 <= s_tdata[20];
			ndone_s1 <= s_tdata[21];
		end
	end

	// Table writes are applied as the beat leaves the input register.
	// Indices past the table are dropped.
	assign tbl_wr.en    = fire_s1 && cmd_s1 == CMD_WRITE && 32'(idx_s1) < TABLE_DEPTH;
	assign tbl_wr.clr   = fire_s1 && cmd_s1 == CMD_CLEAR;
	assign tbl_wr.idx   = IDX_W'(idx_s1);
	assign tbl_wr.field = fsel_s1;
	assign tbl_wr.value = fval_s1;

	assign ptr_inc  = ptr_q + idx_t'(1);
	assign ptr_last = (ptr_q == IDX_W'(TABLE_DEPTH - 1));

	bpts_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_idx   (ptr_q),
		.pole_idx (ptr_n),
		.vld_idx  (ptr_inc),
		.rd       (cur),
		.poles    (poles_n),
		.vld      (nx_vld)
	);

	// First train after the current phase with a nonzero count
	always_comb begin
		adv_from  = (phase_q == PH_STOP) ? 3'd0 : 3'(phase_q);
		adv_sel   = 3'd0;
		adv_found = 1'b0;
		for (int p = 4; p >= 1; p--) begin
			if (3'(p) > adv_from && cur.counts[8*(p-1) +: 8] != 8'd0) begin
				adv_sel   = 3'(p);
				adv_found = 1'b1;
			end
		end
		adv_hv  = (adv_sel <= 3'(PH_HV_NEG));
		adv_pos = (adv_sel == 3'(PH_HV_POS)) || (adv_sel == 3'(PH_LV_POS));
		// Delay: first train of an entry, HV to HV, LV to LV, else between kinds
		if (adv_from == 3'(PH_STOP)) begin
			adv_dly = cur.times[16*T_SEQ_DLY +: 16];
		end else if (adv_from == 3'(PH_HV_POS) && adv_sel == 3'(PH_HV_NEG)) begin
			adv_dly = cur.times[16*T_HV_DLY +: 16];
		end else if (adv_from == 3'(PH_LV_POS) && adv_sel == 3'(PH_LV_NEG)) begin
			adv_dly = cur.times[16*T_LV_DLY +: 16];
		end else begin
			adv_dly = cur.times[16*T_PULSE_DLY +: 16];
		end
	end

	assign pole_done = (phase_q == PH_HV_POS || phase_q == PH_LV_POS) ? pdone_s1 : ndone_s1;

	always_comb begin
		phase_n = phase_q;
		run_n   = run_q;
		ptr_n   = ptr_q;
		sw_mode = SW_KEEP;
		p_mode  = POLE_KEEP;
		n_mode  = POLE_KEEP;
		t_dly   = '0;
		t_on    = '0;
		t_off   = '0;
		t_cnt   = '0;
		rpt     = 1'b0;
		case (cmd_s1)
			CMD_TICK: begin
				if (phase_q == PH_STOP && !run_q) begin
					// idle: hold the bridge off
					sw_mode = SW_OFF;
					p_mode  = POLE_FLOAT;
					n_mode  = POLE_FLOAT;
				end else if (phase_q != PH_STOP && !run_q) begin
					// stopped mid-program: drop back, outputs untouched
					phase_n = PH_STOP;
				end else if (phase_q == PH_STOP || (pole_done && phase_q != PH_LV_NEG)) begin
					if (adv_found) begin
						sw_mode = adv_hv ? SW_HV : SW_LV;
						p_mode  = adv_pos ? POLE_PULSE : POLE_LOW;
						n_mode  = adv_pos ? POLE_LOW : POLE_PULSE;
						t_dly   = adv_dly;
						t_on    = adv_hv ? cur.times[16*T_HV_ON +: 16]
						                 : cur.times[16*T_LV_ON +: 16];
						t_off   = adv_hv ? cur.times[16*T_HV_OFF +: 16]
						                 : cur.times[16*T_LV_OFF +: 16];
						t_cnt   = cur.counts[{adv_sel[1:0] - 2'd1, 3'd0} +: 8];
						phase_n = phase_t'(adv_sel);
					end else begin
						run_n   = 1'b0;
						phase_n = PH_STOP;
					end
				end else if (pole_done) begin
					// last train of the entry finished
					phase_n = PH_STOP;
					if (ptr_last || !nx_vld) begin
						ptr_n = '0;
						run_n = 1'b0;
						rpt   = 1'b1;
					end else begin
						ptr_n  = ptr_inc;
						p_mode = POLE_FLOAT;
						n_mode = POLE_FLOAT;
					end
				end
			end
			CMD_START: run_n = 1'b1;
			CMD_STOP:  run_n = 1'b0;
			CMD_WRITE: ;
			CMD_CLEAR: ptr_n = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STOP;
			run_q     <= 1'b0;
			ptr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				phase_q   <= phase_n;
				run_q     <= run_n;
				ptr_q     <= ptr_n;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= {run_n, 3'(phase_n), rpt, poles_n[7:4], poles_n[3:0], t_cnt,
			          t_off, t_on, t_dly, n_mode, p_mode, sw_mode};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, res_q};

`ifndef ASSERT_OFF
	// a finished program always reports stopped and disabled
	a_report_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q[70] |-> res_q[73:71] == 3'(PH_STOP) && !res_q[74])
		else $error("stop_report without stop phase");

	// entry pointer only moves on a tick or a table clear
	a_ptr_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ptr_q) |-> $past(fire_s1 && (cmd_s1 == CMD_TICK || cmd_s1 == CMD_CLEAR)))
		else $error("entry pointer moved without tick or clear");

	// a train is only entered from stop while running
	a_train_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_STOP && $past(phase_q) == PH_STOP |-> $past(run_q))
		else $error("train started while not running");

	// both registers full and stalled: input side must hold off
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_vld_q && !m_tready |-> !s_tready)
		else $error("beat accepted into full pipeline");
`endif

endmodule

`default_nettype wire

// ----- verif/bipolar_pulse_train_sequencer_core_tb.sv -----
`timescale 1ns / 1ps

module bipolar_pulse_train_sequencer_core_tb;
	import bpts_pkg::*;

	localparam int TARGET_BEATS   = 1800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;
	localparam int MAX_REPORTS    = 10;
	// field_select value with no field behind it
	localparam logic [3:0] FLD_NONE = 4'd15;

	// Result beat, laid out exactly as m_tdata[74:0] (top field first)
	typedef struct packed {
		logic        en;
		phase_t      ph;
		logic        report;
		logic [3:0]  neg_el;
		logic [3:0]  pos_el;
		logic [7:0]  count;
		logic [15:0] off_ms;
		logic [15:0] on_ms;
		logic [15:0] delay_ms;
		logic [1:0]  neg_mode;
		logic [1:0]  pos_mode;
		logic [1:0]  switch_mode;
	} pulse_result_t;

	// Tracks the sequencer and the program table, predicts one result per
	// input beat and checks output beats in order.
	class pulse_program_scoreboard;
		pulse_result_t expected_q[$];
		bit [1:0]      el_known_q[$];   // {neg, pos} electrode written yet
		int            mismatches;

		phase_t      cur_ph;
		bit          running;
		idx_t        entry_ptr;
		bit          valid_mark[TABLE_DEPTH];
		logic [7:0]  train_len[TABLE_DEPTH][4];
		logic [15:0] times[TABLE_DEPTH][N_TIMES];
		logic [3:0]  pos_el[TABLE_DEPTH];
		logic [3:0]  neg_el[TABLE_DEPTH];
		bit [13:0]   written[TABLE_DEPTH];

		function new();
			cur_ph     = PH_STOP;
			running    = 1'b0;
			entry_ptr  = '0;
			mismatches = 0;
			foreach (valid_mark[k]) begin
				valid_mark[k] = 1'b0;
				written[k]    = '0;
			end
		endfunction

		function bit entry_loaded(idx_t e);
			return &written[e];
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void load_train(int p, logic [15:0] dly, inout pulse_result_t r);
			bit hv;
			bit pos;
			hv = (p <= int'(PH_HV_NEG));
			pos = (p == int'(PH_HV_POS)) || (p == int'(PH_LV_POS));
			r.switch_mode = hv ? SW_HV : SW_LV;
			r.pos_mode    = pos ? POLE_PULSE : POLE_LOW;
			r.neg_mode    = pos ? POLE_LOW : POLE_PULSE;
			r.delay_ms    = dly;
			r.on_ms       = times[entry_ptr][hv ? T_HV_ON : T_LV_ON];
			r.off_ms      = times[entry_ptr][hv ? T_HV_OFF : T_LV_OFF];
			r.count       = train_len[entry_ptr][p - 1];
			cur_ph        = phase_t'(3'(p));
		endfunction

		// Load the first train after phase 'from' with a nonzero count
		function void advance(int from, inout pulse_result_t r);
			logic [15:0] dly;
			for (int p = from + 1; p <= int'(PH_LV_NEG); p++) begin
				if (train_len[entry_ptr][p - 1] != 8'd0) begin
					if (from == int'(PH_STOP))
						dly = times[entry_ptr][T_SEQ_DLY];
					else if (from == int'(PH_HV_POS) && p == int'(PH_HV_NEG))
						dly = times[entry_ptr][T_HV_DLY];
					else if (from == int'(PH_LV_POS) && p == int'(PH_LV_NEG))
						dly = times[entry_ptr][T_LV_DLY];
					else
						dly = times[entry_ptr][T_PULSE_DLY];
					load_train(p, dly, r);
					return;
				end
			end
			running = 1'b0;
			cur_ph  = PH_STOP;
		endfunction

		function void tick(logic pd, logic nd, inout pulse_result_t r);
			logic done;
			int   nx;
			if (cur_ph == PH_STOP) begin
				if (!running) begin
					r.switch_mode = SW_OFF;
					r.pos_mode    = POLE_FLOAT;
					r.neg_mode    = POLE_FLOAT;
				end else begin
					advance(int'(PH_STOP), r);
				end
				return;
			end
			if (!running) begin
				cur_ph = PH_STOP;
				return;
			end
			done = (cur_ph == PH_HV_POS || cur_ph == PH_LV_POS) ? pd : nd;
			if (!done)
				return;
			if (cur_ph != PH_LV_NEG) begin
				advance(int'(cur_ph), r);
				return;
			end
			nx = int'(entry_ptr) + 1;
			cur_ph = PH_STOP;
			if (nx < TABLE_DEPTH && valid_mark[nx]) begin
				entry_ptr  = idx_t'(nx);
				r.pos_mode = POLE_FLOAT;
				r.neg_mode = POLE_FLOAT;
			end else begin
				entry_ptr = '0;
				running   = 1'b0;
				r.report  = 1'b1;
			end
		endfunction

		function void store(idx_t e, logic [3:0] f, logic [15:0] v);
			if (f == FLD_POS_EL)
				pos_el[e] = v[3:0];
			else if (f == FLD_NEG_EL)
				neg_el[e] = v[3:0];
			else if (f <= FLD_LV_NEG_CNT)
				train_len[e][f - FLD_HV_POS_CNT] = v[7:0];
			else if (f <= FLD_LV_OFF)
				times[e][f - FLD_SEQ_DLY] = v;
			else if (f == FLD_VALID)
				valid_mark[e] = v[VALID_BIT];
			if (f <= FLD_LV_OFF)
				written[e][f] = 1'b1;
		endfunction

		function void note_beat(logic [2:0] cmd, idx_t e, logic [3:0] f, logic [15:0] v,
				logic pd, logic nd);
			pulse_result_t r;
			r = '0;
			r.switch_mode = SW_KEEP;
			r.pos_mode    = POLE_KEEP;
			r.neg_mode    = POLE_KEEP;
			case (cmd)
				CMD_TICK:  tick(pd, nd, r);
				CMD_START: running = 1'b1;
				CMD_STOP:  running = 1'b0;
				CMD_WRITE: store(e, f, v);
				CMD_CLEAR: begin
					foreach (valid_mark[k])
						valid_mark[k] = 1'b0;
					entry_ptr = '0;
				end
				default: ;
			endcase
			r.pos_el = pos_el[entry_ptr];
			r.neg_el = neg_el[entry_ptr];
			r.ph     = cur_ph;
			r.en     = running;
			expected_q.push_back(r);
			el_known_q.push_back({written[entry_ptr][FLD_NEG_EL],
				written[entry_ptr][FLD_POS_EL]});
		endfunction

		function void flag_field(string label, logic [15:0] got_v, logic [15:0] want_v);
			if (got_v !== want_v) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s mismatch: expected %0h, got %0h",
						$realtime, label, want_v, got_v);
			end
		endfunction

		function void check_beat(logic [79:0] d);
			pulse_result_t got;
			pulse_result_t want;
			bit [1:0]      known;
			got = d[74:0];
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat %h with nothing expected", $realtime, d);
				return;
			end
			want  = expected_q.pop_front();
			known = el_known_q.pop_front();
			flag_field("switch_mode", got.switch_mode, want.switch_mode);
			flag_field("pos_mode", got.pos_mode, want.pos_mode);
			flag_field("neg_mode", got.neg_mode, want.neg_mode);
			flag_field("train_delay_ms", got.delay_ms, want.delay_ms);
			flag_field("train_on_ms", got.on_ms, want.on_ms);
			flag_field("train_off_ms", got.off_ms, want.off_ms);
			flag_field("train_count", got.count, want.count);
			// Electrodes of entry 0 are unknown until the first writes land
			if (known[0])
				flag_field("pos_electrode", got.pos_el, want.pos_el);
			if (known[1])
				flag_field("neg_electrode", got.neg_el, want.neg_el);
			flag_field("stop_report", got.report, want.report);
			flag_field("phase", got.ph, want.ph);
			flag_field("enabled", got.en, want.en);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [6:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;

	pulse_program_scoreboard sb;
	int          beats_sent = 0;
	int          src_calm = 0;     // remaining beats of a no-idle stretch, sender
	int          sink_calm = 0;    // same for the result side
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	bipolar_pulse_train_sequencer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Idle cycles before a beat: mostly none or a short random gap, with
	// occasional stretches where the side never idles.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 18);
	endfunction

	// Random field content; count fields are often zero so trains get skipped
	function automatic logic [15:0] field_data(logic [3:0] f);
		logic [15:0] v;
		v = 16'($urandom);
		if (f >= FLD_HV_POS_CNT && f <= FLD_LV_NEG_CNT && $urandom_range(0, 2) == 0)
			v[7:0] = 8'd0;
		if ($urandom_range(0, 15) == 0)
			v = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
		return v;
	endfunction

	// One input beat: idle gap, then hold tvalid until the handshake
	task automatic send_beat(logic [2:0] cmd, idx_t e, logic [3:0] f, logic [15:0] v,
			logic pd, logic nd);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, nd, pd, v, e};
		s_tuser  <= {f, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_beat(cmd, e, f, v, pd, nd);
		if (cmd <= CMD_CLEAR && !(cmd == CMD_WRITE && f == FLD_NONE))
			beats_sent++;
	endtask

	task automatic send_tick(logic pd, logic nd);
		send_beat(CMD_TICK, 4'($urandom), 4'($urandom), 16'($urandom), pd, nd);
	endtask

	task automatic send_cmd(logic [2:0] cmd);
		send_beat(cmd, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
			1'($urandom));
	endtask

	task automatic send_write(idx_t e, logic [3:0] f, logic [15:0] v);
		send_beat(CMD_WRITE, e, f, v, 1'($urandom), 1'($urandom));
	endtask

	// Writes every payload field of an entry; an entry is only ever marked
	// valid once this has happened, so the sequencer never reads stale rows.
	task automatic load_entry(idx_t e);
		for (int f = int'(FLD_POS_EL); f <= int'(FLD_LV_OFF); f++)
			send_write(e, 4'(f), field_data(4'(f)));
	endtask

	task automatic write_random_field();
		idx_t        e;
		logic [3:0]  f;
		logic [15:0] v;
		e = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom);
		f = 4'($urandom);
		v = field_data(f);
		if (f == FLD_VALID && !sb.entry_loaded(e))
			v[VALID_BIT] = 1'b0;
		send_write(e, f, v);
	endtask

	// Mark a run of entries after entry 0 so programs chain across entries
	task automatic mark_chain();
		int          k;
		logic [15:0] v;
		k = $urandom_range(1, 5);
		for (int e = 1; e <= k; e++) begin
			v = 16'($urandom);
			v[VALID_BIT] = sb.entry_loaded(idx_t'(e)) && ($urandom_range(0, 3) != 0);
			send_write(idx_t'(e), FLD_VALID, v);
		end
	endtask

	// Sender holds off until every predicted result has been taken
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic directed_beats();
		send_tick(1'b0, 1'b0);                          // idle tick: all off
		for (int c = int'(CMD_CLEAR) + 1; c < 8; c++)   // undefined commands
			send_cmd(3'(c));
		send_write(4'd15, FLD_NONE, 16'hFFFF);          // no such field
		send_write(4'd15, FLD_POS_EL, 16'hFFFF);
		send_write(4'd15, FLD_SEQ_DLY, 16'h0000);
		// entry with every count zero: the tick after start clears the run flag
		for (int f = int'(FLD_HV_POS_CNT); f <= int'(FLD_LV_NEG_CNT); f++)
			send_write(4'd0, 4'(f), 16'hFF00);
		send_cmd(CMD_START);
		send_tick(1'b1, 1'b1);
		// HV positive then LV negative, middle trains skipped; entry 1 is not
		// valid so the last done ends the program with a report
		send_write(4'd0, FLD_HV_POS_CNT, 16'h00FF);
		send_write(4'd0, FLD_LV_NEG_CNT, 16'h0001);
		send_write(4'd0, FLD_SEQ_DLY, 16'hFFFF);
		send_cmd(CMD_START);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);                          // wrong pole done
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		// stop while a train runs: next tick parks in stop, modes unchanged
		send_cmd(CMD_START);
		send_tick(1'b0, 1'b0);
		send_cmd(CMD_STOP);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_cmd(CMD_CLEAR);
	endtask

	// Table edits, start, then a run of ticks with random pole done flags and
	// a sprinkling of stray commands.
	task automatic program_episode();
		int n;
		int roll;
		if ($urandom_range(0, 2) == 0)
			load_entry(($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 5)) : 4'($urandom));
		n = $urandom_range(0, 4);
		repeat (n) write_random_field();
		if ($urandom_range(0, 1) == 0)
			mark_chain();
		if ($urandom_range(0, 9) == 0)
			send_cmd(CMD_CLEAR);
		send_cmd(CMD_START);
		n = $urandom_range(4, 48);
		repeat (n) begin
			roll = $urandom_range(0, 29);
			case (roll)
				0: send_cmd(CMD_STOP);
				1: send_cmd(CMD_START);
				2: write_random_field();
				3: send_cmd(3'($urandom_range(int'(CMD_CLEAR) + 1, 7)));
				4: send_cmd(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_TICK);
				default: send_tick($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
			endcase
		end
	endtask

	// Main sequence: reset, table load, directed beats, random programs
	initial begin
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		load_entry(4'd0);
		directed_beats();
		hold_until_drained();
		while (beats_sent < TARGET_BEATS) begin
			program_episode();
			if ($urandom_range(0, 5) == 0)
				hold_until_drained();
		end
		hold_until_drained();
		// a stray beat after the last expected one still gets flagged here
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, every accepted beat goes to the checker
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_beat(m_tdata);
		end
	end

	// Watchdog: any beat on either side counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
